// ===== design/hsl_saturation_replace_macros.svh =====
// assertion macros shared by the checker of hsl_saturation_replace
`ifndef HSL_SATURATION_REPLACE_MACROS_SVH
`define HSL_SATURATION_REPLACE_MACROS_SVH

// same-cycle implication, quiet while reset is held
`define HSLSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication with a fixed delay, quiet while reset is held
`define HSLSR_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

// ===== design/hslsr_pkg.sv =====
`timescale 1ns / 1ps

package hslsr_pkg;

  // which channel holds the maximum, picks the hue base 0, 2 or 4
  localparam logic [1:0] BASE_RED   = 2'd0;
  localparam logic [1:0] BASE_GREEN = 2'd1;
  localparam logic [1:0] BASE_BLUE  = 2'd2;

  // per-item data that rides alongside the hue divider
  typedef struct packed {
    logic [1:0] base;   // max channel code
    logic       neg;    // hue ratio numerator is negative
    logic       gray;   // max equals min
    logic [7:0] k;      // 255 * (1 - |2L - 1|)
    logic [7:0] sat;    // new saturation code
    logic [8:0] sum;    // max + min
  } hslsr_side_t;

endpackage

// ===== design/hslsr_div.sv =====
`timescale 1ns / 1ps

module hslsr_div import hslsr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [7:0]           in_num,
  input  logic [7:0]           in_den,
  input  hslsr_side_t          in_side,
  output logic                 out_valid,
  output logic [FRAC_BITS:0]   out_quot,
  output hslsr_side_t          out_side
);

  // round(num * 2^F / den) for num <= den, one quotient bit per stage
  localparam int QW = FRAC_BITS + 1;

  logic              valid_r [0:FRAC_BITS];
  logic [7:0]        rem_r   [0:FRAC_BITS];
  logic [7:0]        den_r   [0:FRAC_BITS];
  logic [QW-1:0]     quot_r  [0:FRAC_BITS];
  hslsr_side_t       side_r  [0:FRAC_BITS];

  logic              qtop_nxt;
  logic [7:0]        rem0_nxt;

  // integer bit: set only when num equals den
  assign qtop_nxt = (in_num >= in_den);
  assign rem0_nxt = qtop_nxt ? (in_num - in_den) : in_num;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0]  <= rem0_nxt;
    den_r[0]  <= in_den;
    quot_r[0] <= {qtop_nxt, FRAC_BITS'(0)};
    side_r[0] <= in_side;
  end

  // fraction bits; the shifted-in dividend bits are those of floor(den / 2)
  for (genvar j = 1; j <= FRAC_BITS; j++) begin : g_step
    localparam int BIT = FRAC_BITS - j;
    logic          hb;
    logic [8:0]    shifted;
    logic [8:0]    trial;
    logic          ge;
    logic [7:0]    rem_nxt;
    logic [QW-1:0] quot_nxt;

    if (BIT < 7) begin : g_hb
      assign hb = den_r[j-1][BIT+1];
    end else begin : g_nohb
      assign hb = 1'b0;
    end

    assign shifted = {rem_r[j-1], hb};
    assign trial   = shifted - {1'b0, den_r[j-1]};
    assign ge      = (shifted >= {1'b0, den_r[j-1]});
    assign rem_nxt = ge ? trial[7:0] : shifted[7:0];

    always_comb begin
      quot_nxt      = quot_r[j-1];
      quot_nxt[BIT] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[j] <= 1'b0;
      end else begin
        valid_r[j] <= valid_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j]  <= rem_nxt;
      den_r[j]  <= den_r[j-1];
      quot_r[j] <= quot_nxt;
      side_r[j] <= side_r[j-1];
    end
  end

  assign out_valid = valid_r[FRAC_BITS];
  assign out_quot  = quot_r[FRAC_BITS];
  assign out_side  = side_r[FRAC_BITS];

endmodule

// ===== design/hslsr_front.sv =====
`timescale 1ns / 1ps

module hslsr_front import hslsr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_sat,
  output logic        out_valid,
  output logic [7:0]  out_num,
  output logic [7:0]  out_den,
  output hslsr_side_t out_side
);

  logic        v0_r;
  logic [7:0]  red_r, green_r, blue_r, sat_r;

  logic        v1_r;
  logic [7:0]  num_r, den_r;
  hslsr_side_t side_r;

  logic [7:0]  mx, mn, opa, opb;
  logic [8:0]  sum;
  logic [8:0]  kwide;
  hslsr_side_t side_nxt;
  logic [7:0]  num_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
    end else begin
      v0_r <= in_valid;
      v1_r <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= in_red;
    green_r <= in_green;
    blue_r  <= in_blue;
    sat_r   <= in_sat;
  end

  always_comb begin
    mx = red_r;
    if (green_r > mx) mx = green_r;
    if (blue_r > mx) mx = blue_r;
    mn = red_r;
    if (green_r < mn) mn = green_r;
    if (blue_r < mn) mn = blue_r;

    sum   = {1'b0, mx} + {1'b0, mn};
    kwide = (sum >= 9'd255) ? (9'd510 - sum) : sum;

    // red wins ties for the max, then green
    if (mx == red_r) begin
      side_nxt.base = BASE_RED;
      opa = green_r;
      opb = blue_r;
    end else if (mx == green_r) begin
      side_nxt.base = BASE_GREEN;
      opa = blue_r;
      opb = red_r;
    end else begin
      side_nxt.base = BASE_BLUE;
      opa = red_r;
      opb = green_r;
    end

    side_nxt.neg  = (opa < opb);
    side_nxt.gray = (mx == mn);
    side_nxt.k    = kwide[7:0];
    side_nxt.sat  = sat_r;
    side_nxt.sum  = sum;
    num_nxt       = side_nxt.neg ? (opb - opa) : (opa - opb);
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den_r  <= mx - mn;
    side_r <= side_nxt;
  end

  assign out_valid = v1_r;
  assign out_num   = num_r;
  assign out_den   = den_r;
  assign out_side  = side_r;

endmodule

// ===== design/hslsr_back.sv =====
`timescale 1ns / 1ps

module hslsr_back import hslsr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [FRAC_BITS:0] in_quot,
  input  hslsr_side_t        in_side,
  output logic               out_valid,
  output logic [7:0]         out_red,
  output logic [7:0]         out_green,
  output logic [7:0]         out_blue
);

  localparam int HW = FRAC_BITS + 3;   // h6 in [0, 6)
  localparam int FW = FRAC_BITS + 1;   // factor in [0, 1]
  localparam int UW = 17;              // channel sums in 1/510 LSB
  localparam int PW = UW + FW;

  localparam logic [HW-1:0]  ONE_FX  = HW'(1) << FRAC_BITS;
  localparam logic [HW-1:0]  TWO_FX  = HW'(2) << FRAC_BITS;
  localparam logic [HW-1:0]  FOUR_FX = HW'(4) << FRAC_BITS;
  localparam logic [HW-1:0]  SIX_FX  = HW'(6) << FRAC_BITS;
  localparam logic [PW:0]    HALF_FX = (PW+1)'(1) << (FRAC_BITS - 1);

  // floor(y / 255) == (y * RECIP_255) >> RECIP_SHIFT for y < 2^16
  localparam logic [32:0]    RECIP_255   = 33'd65794;
  localparam int             RECIP_SHIFT = 24;
  localparam logic [UW-1:0]  UNIT_BIAS   = UW'(255);

  // hue sectors of h6
  localparam logic [2:0] SEC_RY = 3'd0;
  localparam logic [2:0] SEC_YG = 3'd1;
  localparam logic [2:0] SEC_GC = 3'd2;
  localparam logic [2:0] SEC_CB = 3'd3;
  localparam logic [2:0] SEC_BM = 3'd4;

  function automatic logic [7:0] to_chan(input logic [UW-1:0] u);
    logic [UW-1:0] biased;
    logic [32:0]   p;
    begin
      biased = u + UNIT_BIAS;
      p      = 33'(biased[UW-1:1]) * RECIP_255;
      return p[RECIP_SHIFT+7:RECIP_SHIFT];
    end
  endfunction

  logic v1_r, v2_r, v3_r, v4_r;

  // p1: hue, chroma and match in 1/510 LSB units
  logic [HW-1:0] q_ext, base_fx, h6_nxt, h6_r;
  logic [15:0]   ks;
  logic [UW-1:0] cu_nxt, match_nxt, cu_r, match_r;

  assign q_ext = HW'(in_quot);

  always_comb begin
    case (in_side.base)
      BASE_GREEN: base_fx = TWO_FX;
      BASE_BLUE:  base_fx = FOUR_FX;
      default:    base_fx = '0;
    endcase
    if (in_side.gray) begin
      h6_nxt = '0;
    end else if (in_side.neg) begin
      h6_nxt = (in_side.base == BASE_RED) ? (SIX_FX - q_ext) : (base_fx - q_ext);
    end else begin
      h6_nxt = base_fx + q_ext;
    end
    if (h6_nxt >= SIX_FX) h6_nxt = SIX_FX - ONE_FX + (ONE_FX - HW'(1));
  end

  assign ks        = 16'(in_side.k) * 16'(in_side.sat);
  assign cu_nxt    = {ks, 1'b0};
  assign match_nxt = UW'({in_side.sum, 8'b0}) - UW'(in_side.sum) - UW'(ks);

  always_ff @(posedge clk) begin
    h6_r    <= h6_nxt;
    cu_r    <= cu_nxt;
    match_r <= match_nxt;
  end

  // p2: factor = 1 - |(h6 mod 2) - 1|, times chroma
  logic [FW-1:0] t, factor;
  logic [2:0]    sector_r;
  logic [UW-1:0] cu2_r, match2_r;
  logic [PW-1:0] prod_r;

  assign t      = h6_r[FRAC_BITS:0];
  assign factor = t[FRAC_BITS] ? (~t + FW'(1)) : t;

  always_ff @(posedge clk) begin
    sector_r <= h6_r[FRAC_BITS+2:FRAC_BITS];
    cu2_r    <= cu_r;
    match2_r <= match_r;
    prod_r   <= PW'(cu_r) * PW'(factor);
  end

  // p3: round the second component, place by sector, add match
  logic [PW:0]   rnd;
  logic [UW-1:0] xu, cr, cg, cb;
  logic [UW-1:0] ured_r, ugrn_r, ublu_r;

  assign rnd = (PW+1)'(prod_r) + HALF_FX;
  assign xu  = rnd[FRAC_BITS+UW-1:FRAC_BITS];

  always_comb begin
    cr = '0;
    cg = '0;
    cb = '0;
    case (sector_r)
      SEC_RY: begin cr = cu2_r; cg = xu;    end
      SEC_YG: begin cr = xu;    cg = cu2_r; end
      SEC_GC: begin cg = cu2_r; cb = xu;    end
      SEC_CB: begin cg = xu;    cb = cu2_r; end
      SEC_BM: begin cr = xu;    cb = cu2_r; end
      default: begin cr = cu2_r; cb = xu;   end
    endcase
  end

  always_ff @(posedge clk) begin
    ured_r <= cr + match2_r;
    ugrn_r <= cg + match2_r;
    ublu_r <= cb + match2_r;
  end

  // p4: divide by 510, round half up
  logic [7:0] ored_r, ogrn_r, oblu_r;

  always_ff @(posedge clk) begin
    ored_r <= to_chan(ured_r);
    ogrn_r <= to_chan(ugrn_r);
    oblu_r <= to_chan(ublu_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_red   = ored_r;
  assign out_green = ogrn_r;
  assign out_blue  = oblu_r;

endmodule

// ===== design/hsl_saturation_replace.sv =====
`timescale 1ns / 1ps
// channel   ports                                        handshake
// --------  -------------------------------------------  ----------------------------
// input     in_red, in_green, in_blue, in_new_saturation  start high, busy low
// result    out_red, out_green, out_blue                  out_valid high for one cycle
//
// one item enters per cycle; busy never rises, so start may stay high
// the hue divider spends one stage per quotient bit
// synchronous active-low reset clears every valid bit; items in flight are dropped
// results are strobed out and must be taken in the cycle they appear

module hsl_saturation_replace import hslsr_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_new_saturation,
  output logic       out_valid,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  // front: input register, then max/min, chroma factor and hue numerator
  logic               fr_valid;
  logic [7:0]         fr_num, fr_den;
  hslsr_side_t        fr_side;

  // divider output: hue ratio with FRAC_BITS fraction bits
  logic               dv_valid;
  logic [FRAC_BITS:0] dv_quot;
  hslsr_side_t        dv_side;

  // fully pipelined, nothing ever holds the input off
  assign busy = 1'b0;

  hslsr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (start & ~busy),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .in_sat    (in_new_saturation),
    .out_valid (fr_valid),
    .out_num   (fr_num),
    .out_den   (fr_den),
    .out_side  (fr_side)
  );

  // restoring division, one bit per stage; the gray case is masked later
  hslsr_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fr_valid),
    .in_num    (fr_num),
    .in_den    (fr_den),
    .in_side   (fr_side),
    .out_valid (dv_valid),
    .out_quot  (dv_quot),
    .out_side  (dv_side)
  );

  // back end: hue assembly, sector mixing, divide by 510 and round
  hslsr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (dv_valid),
    .in_quot   (dv_quot),
    .in_side   (dv_side),
    .out_valid (out_valid),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue)
  );

endmodule

// ===== design/hslsr_checker.sv =====
`timescale 1ns / 1ps
`include "hsl_saturation_replace_macros.svh"

module hslsr_checker #(
  parameter int FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [7:0] in_red,
  input logic [7:0] in_green,
  input logic [7:0] in_blue,
  input logic [7:0] in_new_saturation,
  input logic       out_valid,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue
);

  localparam int LAT = FRAC_BITS + 7;

  // every strobe traces back to an item taken a fixed latency earlier
  `HSLSR_ASSERT_IMP(a_strobe_has_item, out_valid, $past(start && !busy, LAT), "strobe without item")

  // black stays black
  `HSLSR_ASSERT_DLY(a_black_kept, start && !busy && in_red == 8'd0 && in_green == 8'd0 && in_blue == 8'd0, LAT, out_valid && out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0, "black not kept")

  // white stays white
  `HSLSR_ASSERT_DLY(a_white_kept, start && !busy && in_red == 8'd255 && in_green == 8'd255 && in_blue == 8'd255, LAT, out_valid && out_red == 8'd255 && out_green == 8'd255 && out_blue == 8'd255, "white not kept")

  // zero saturation gives a gray result
  `HSLSR_ASSERT_DLY(a_zero_sat_gray, start && !busy && in_new_saturation == 8'd0, LAT, out_valid && out_red == out_green && out_green == out_blue, "zero saturation not gray")

endmodule

bind hsl_saturation_replace hslsr_checker #(.FRAC_BITS(FRAC_BITS)) u_hslsr_checker (.*);
